// ===== hdl/mqs_pkg.sv =====
`default_nettype none
package mqs_pkg;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DEQ
  } state_t;

  typedef struct packed {
    logic [7:0]  sender;
    logic [7:0]  ttl;
    logic [31:0] payload;
  } entry_t;

endpackage
`default_nettype wire

// ===== hdl/mqs_ifs.sv =====
`default_nettype none
interface mqs_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [3:0]  queue_id;
  logic [7:0]  sender_id;
  logic [7:0]  time_to_live;
  logic [31:0] payload;

  modport source (output valid, cmd, queue_id, sender_id, time_to_live, payload,
                  input ready);
  modport sink (input valid, cmd, queue_id, sender_id, time_to_live, payload,
                output ready);
endinterface

interface mqs_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  out_sender;
  logic [7:0]  out_ttl;
  logic [31:0] out_payload;

  modport source (output valid, status, out_sender, out_ttl, out_payload,
                  input ready);
  modport sink (input valid, status, out_sender, out_ttl, out_payload,
                output ready);
endinterface
`default_nettype wire

// ===== hdl/mqs_pool.sv =====
`default_nettype none
// Shared entry pool: message words and next-entry links.
module mqs_pool #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          ent_we,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] ent_waddr,
  input  wire mqs_pkg::entry_t               ent_wdata,
  input  wire logic                          ent_re,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] ent_raddr,
  output mqs_pkg::entry_t                    ent_rdata,
  input  wire logic                          link_we,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] link_waddr,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] link_wdata,
  input  wire logic                          link_re,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] link_raddr,
  output logic      [$clog2(POOL_DEPTH)-1:0] link_rdata
);
  localparam int PW = $clog2(POOL_DEPTH);

  mqs_pkg::entry_t ent_mem  [POOL_DEPTH];
  logic [PW-1:0]   link_mem [POOL_DEPTH];

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rdata <= link_mem[link_raddr];
    end
  end
endmodule
`default_nettype wire

// ===== hdl/mqs_qtab.sv =====
`default_nettype none
// Per-queue head/tail pointers and nonempty flags.
module mqs_qtab #(
  parameter int NUM_QUEUES = 16,
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(NUM_QUEUES)-1:0] rd_addr,
  output logic      [$clog2(POOL_DEPTH)-1:0] head_rd,
  output logic      [$clog2(POOL_DEPTH)-1:0] tail_rd,
  input  wire logic [$clog2(NUM_QUEUES)-1:0] wr_addr,
  input  wire logic                          head_we,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] head_wdata,
  input  wire logic                          tail_we,
  input  wire logic [$clog2(POOL_DEPTH)-1:0] tail_wdata,
  input  wire logic                          ne_set,
  input  wire logic                          ne_clr,
  output logic                               ne_rd
);
  localparam int PW = $clog2(POOL_DEPTH);

  logic [PW-1:0]         head_mem [NUM_QUEUES];
  logic [PW-1:0]         tail_mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] nonempty;

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[wr_addr] <= head_wdata;
    end
    if (rd_en) begin
      head_rd <= head_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (tail_we) begin
      tail_mem[wr_addr] <= tail_wdata;
    end
    if (rd_en) begin
      tail_rd <= tail_mem[rd_addr];
    end
  end

  // pointers of a queue are only trusted while its flag is set
  always_ff @(posedge clk) begin
    if (rst) begin
      nonempty <= '0;
    end else if (ne_set) begin
      nonempty[wr_addr] <= 1'b1;
    end else if (ne_clr) begin
      nonempty[wr_addr] <= 1'b0;
    end
  end

  assign ne_rd = nonempty[wr_addr];
endmodule
`default_nettype wire

// ===== hdl/multi_queue_message_store_unit.sv =====
`default_nettype none
// Bank of NUM_QUEUES message FIFOs held as linked lists in one pool of
// POOL_DEPTH entries. Each request transaction (enqueue or dequeue) gives
// exactly one response transaction. A small sequencer drives pointer, link
// and entry memories with registered reads: an enqueue, or a rejected
// request (queue empty, pool full, queue index out of range), passes through
// S_IDLE and S_LOOK and loads the response register from S_LOOK; a
// successful dequeue goes on to S_DEQ and loads it from there, the extra
// step being the read of the head entry and its link. One request is in
// work at a time; ready is high only while the sequencer is idle. The
// sequencer holds its final step while an earlier response still waits in
// the output register. Never-used entries are handed out from a fill
// counter, so the link memory needs no clearing pass after reset.
module multi_queue_message_store_unit #(
  parameter int NUM_QUEUES = 16,
  parameter int POOL_DEPTH = 64
) (
  input wire logic clk,
  input wire logic rst,
  mqs_req_if.sink  req,
  mqs_rsp_if.source rsp
);
  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(POOL_DEPTH);
  localparam int FW = $clog2(POOL_DEPTH + 1);

  mqs_pkg::state_t state, state_next;

  logic            cmd_r;
  logic [QW-1:0]   q_r;
  logic            q_ok;
  mqs_pkg::entry_t item;

  logic [PW-1:0] free_head, free_head_next;
  logic [FW-1:0] fresh, fresh_next;
  logic [FW-1:0] free_count, free_count_next;

  logic                    out_valid;
  logic                    load_out;
  logic                    out_free;
  mqs_pkg::status_t        status_r, status_next;
  mqs_pkg::entry_t         out_msg, out_msg_next;

  logic            ent_we, ent_re;
  logic [PW-1:0]   ent_waddr;
  mqs_pkg::entry_t ent_rdata;
  logic            link_we, link_re;
  logic [PW-1:0]   link_waddr, link_wdata, link_raddr, link_rdata;
  logic [PW-1:0]   alloc;

  logic          q_re;
  logic [PW-1:0] head_rd, tail_rd;
  logic          head_we, tail_we;
  logic [PW-1:0] head_wdata;
  logic          ne_set, ne_clr, ne_rd;
  logic          accept;

  mqs_pool #(.POOL_DEPTH(POOL_DEPTH)) u_pool (
    .clk        (clk),
    .ent_we     (ent_we),
    .ent_waddr  (ent_waddr),
    .ent_wdata  (item),
    .ent_re     (ent_re),
    .ent_raddr  (head_rd),
    .ent_rdata  (ent_rdata),
    .link_we    (link_we),
    .link_waddr (link_waddr),
    .link_wdata (link_wdata),
    .link_re    (link_re),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  mqs_qtab #(.NUM_QUEUES(NUM_QUEUES), .POOL_DEPTH(POOL_DEPTH)) u_qtab (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (q_re),
    .rd_addr    (QW'(req.queue_id)),
    .head_rd    (head_rd),
    .tail_rd    (tail_rd),
    .wr_addr    (q_r),
    .head_we    (head_we),
    .head_wdata (head_wdata),
    .tail_we    (tail_we),
    .tail_wdata (alloc),
    .ne_set     (ne_set),
    .ne_clr     (ne_clr),
    .ne_rd      (ne_rd)
  );

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;
  // fresh entries first, then the recycled stack
  assign alloc    = (fresh != FW'(POOL_DEPTH)) ? fresh[PW-1:0] : free_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    req.ready       = 1'b0;
    q_re            = 1'b0;
    link_re         = 1'b0;
    link_raddr      = free_head;
    link_we         = 1'b0;
    link_waddr      = tail_rd;
    link_wdata      = alloc;
    ent_we          = 1'b0;
    ent_re          = 1'b0;
    ent_waddr       = alloc;
    head_we         = 1'b0;
    head_wdata      = alloc;
    tail_we         = 1'b0;
    ne_set          = 1'b0;
    ne_clr          = 1'b0;
    free_head_next  = free_head;
    fresh_next      = fresh;
    free_count_next = free_count;
    load_out        = 1'b0;
    status_next     = mqs_pkg::ST_ENQUEUED;
    out_msg_next    = '0;
    unique case (state)
      mqs_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          q_re       = 1'b1;
          link_re    = 1'b1;
          state_next = mqs_pkg::S_LOOK;
        end
      end
      mqs_pkg::S_LOOK: begin
        if (cmd_r == mqs_pkg::CMD_ENQ) begin
          if (out_free) begin
            load_out   = 1'b1;
            state_next = mqs_pkg::S_IDLE;
            if (!q_ok || free_count == '0) begin
              status_next = mqs_pkg::ST_FULL;
            end else begin
              status_next     = mqs_pkg::ST_ENQUEUED;
              ent_we          = 1'b1;
              free_count_next = free_count - FW'(1);
              if (fresh != FW'(POOL_DEPTH)) begin
                fresh_next = fresh + FW'(1);
              end else begin
                free_head_next = link_rdata;
              end
              if (ne_rd) begin
                link_we = 1'b1;
              end else begin
                head_we = 1'b1;
              end
              tail_we = 1'b1;
              ne_set  = 1'b1;
            end
          end
        end else if (!q_ok || !ne_rd) begin
          if (out_free) begin
            load_out    = 1'b1;
            status_next = mqs_pkg::ST_EMPTY;
            state_next  = mqs_pkg::S_IDLE;
          end
        end else begin
          link_re    = 1'b1;
          link_raddr = head_rd;
          ent_re     = 1'b1;
          state_next = mqs_pkg::S_DEQ;
        end
      end
      mqs_pkg::S_DEQ: begin
        if (out_free) begin
          load_out     = 1'b1;
          status_next  = mqs_pkg::ST_DEQUEUED;
          out_msg_next = ent_rdata;
          if (head_rd == tail_rd) begin
            ne_clr = 1'b1;
          end else begin
            head_we    = 1'b1;
            head_wdata = link_rdata;
          end
          // push the freed entry onto the recycled stack
          link_we        = 1'b1;
          link_waddr     = head_rd;
          link_wdata     = free_head;
          free_head_next = head_rd;
          if (free_count != FW'(POOL_DEPTH)) begin
            free_count_next = free_count + FW'(1);
          end
          state_next = mqs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mqs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      fresh      <= '0;
      free_count <= FW'(POOL_DEPTH);
    end else begin
      free_head  <= free_head_next;
      fresh      <= fresh_next;
      free_count <= free_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r        <= req.cmd;
      q_r          <= QW'(req.queue_id);
      q_ok         <= (32'(req.queue_id) < 32'(NUM_QUEUES));
      item.sender  <= req.sender_id;
      item.ttl     <= req.time_to_live;
      item.payload <= req.payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= status_next;
      out_msg  <= out_msg_next;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = status_r;
  assign rsp.out_sender  = out_msg.sender;
  assign rsp.out_ttl     = out_msg.ttl;
  assign rsp.out_payload = out_msg.payload;
endmodule
`default_nettype wire

// ===== hdl/mqs_check.sv =====
`default_nettype none
module mqs_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [1:0]  status,
  input wire logic [7:0]  out_sender,
  input wire logic [7:0]  out_ttl,
  input wire logic [31:0] out_payload
);
  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while previous one in work");

  // message fields carry data only for a dequeued message
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != mqs_pkg::ST_DEQUEUED) |->
      (out_sender == '0 && out_ttl == '0 && out_payload == '0))
    else $error("nonzero message fields on non-dequeue response");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(status) && $stable(out_payload)))
    else $error("stalled response changed or dropped");
endmodule

bind multi_queue_message_store_unit mqs_check u_mqs_check (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .status      (rsp.status),
  .out_sender  (rsp.out_sender),
  .out_ttl     (rsp.out_ttl),
  .out_payload (rsp.out_payload)
);
`default_nettype wire
